@@ src/sds_pkg.sv @@
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared widths, reset values, register indexes and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  // Field widths
  localparam int POS_W  = 16;
  localparam int DISK_W = 17;
  localparam int SEEK_W = 17;
  localparam int CFG_IDX_W = 2;

  // Default capacity of the request store
  localparam int MAX_REQ_DEF = 32;

  // Register reset values
  localparam logic [DISK_W-1:0] DISK_SIZE_RST  = 17'h10000;
  localparam logic [POS_W-1:0]  START_HEAD_RST = 16'h0000;
  localparam logic              SWEEP_UP_RST   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_STEP,
    ST_OUT
  } sds_state_t;

  // Schedule phase: counting pass, first leg, leg after the turnaround
  typedef enum logic [1:0] {
    PH_CNT,
    PH_A,
    PH_B
  } sds_phase_t;

endpackage

`default_nettype wire

@@ src/scan_disk_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// SCAN disk scheduler
// Collects a batch of cylinder requests and plays it back in elevator order.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ channel, one word per accepted cycle while the
// block is loading. Up to MAX_REQUESTS are kept; extra ones are discarded and
// out_dropped is set on every result of that batch. The word with
// in_batch_end set closes the batch and starts the schedule; in_stall then
// stays high until the last result has been taken.
// Results leave on the out_ channel: the start head first, then each request
// on the leading side, the disk edge (out_at_edge), then the other side.
// out_run_end marks the last result, which carries the total seek.
// Sequencing: a counting pass over the store comes before the start head is
// shown. Every request result needs a full pass over the store through its
// single read port plus a step state; the edge result is made in the step
// state alone. A stalled result simply holds in the output register and
// the sequencer waits.
// Reset (synchronous, rst_n low) empties the batch and loads the register
// defaults; the request memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_disk_scheduler_top #(
  parameter int MAX_REQUESTS = sds_pkg::MAX_REQ_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Configuration write port
  input  wire                          cfg_wr_en,
  input  wire  [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [sds_pkg::DISK_W-1:0]   cfg_wr_data,
  // Request channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [sds_pkg::POS_W-1:0]    in_cylinder,
  input  wire                          in_batch_end,
  // Result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [sds_pkg::POS_W-1:0]    out_position,
  output logic                         out_at_edge,
  output logic [sds_pkg::SEEK_W-1:0]   out_total_seek,
  output logic                         out_dropped,
  output logic                         out_run_end
);

  import sds_pkg::*;

  localparam int IW = $clog2(MAX_REQUESTS + 1);
  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int KW = POS_W + IW;
  localparam logic [IW-1:0] MAX_CNT = IW'(MAX_REQUESTS);

  // Configuration registers
  logic [DISK_W-1:0] disk_size_r;
  logic [POS_W-1:0]  start_head_r;
  logic              sweep_up_r;

  // Control state
  sds_state_t state_r, state_nxt;
  sds_phase_t phase_r, phase_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic          rd_vld_r;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Datapath registers
  logic [IW-1:0]    rd_idx_r;
  logic [POS_W-1:0] rd_data_r;
  logic [KW-1:0]    best_r, best_nxt;
  logic [KW-1:0]    cur_r, cur_nxt;
  logic [IW-1:0]    split_r, split_nxt;
  logic [IW-1:0]    rem_r, rem_nxt;
  logic             dir_r, dir_nxt;
  logic [POS_W-1:0] top_r, top_nxt;
  logic [POS_W-1:0] head0_r, head0_nxt;
  logic [POS_W-1:0] head_r, head_nxt;
  logic [SEEK_W-1:0] seek_r, seek_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             out_edge_r, out_edge_nxt;
  logic [SEEK_W-1:0] out_seek_r, out_seek_nxt;
  logic             out_run_end_r, out_run_end_nxt;

  // Request memory
  logic [POS_W-1:0] mem [MAX_REQUESTS];

  // Handshake and helper signals
  logic             in_acc;
  logic             out_acc;
  logic             mem_we;
  logic             rd_en;
  logic             scan_done;
  logic [POS_W-1:0] top_calc;
  logic [POS_W-1:0] sat_v;
  logic [KW-1:0]    key_c;
  logic             in_leg;
  logic             better;
  logic [KW-1:0]    bound_key;
  logic [IW-1:0]    leg_a_cnt;
  logic [POS_W-1:0] target;
  logic [POS_W-1:0] sub_a;
  logic [POS_W-1:0] sub_b;
  logic [POS_W-1:0] delta;
  logic [SEEK_W-1:0] seek_sum;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign mem_we    = in_acc && (count_r < MAX_CNT);
  assign rd_en     = (state_r == ST_SCAN) && (addr_r < count_r);
  assign scan_done = (addr_r == count_r) && !rd_vld_r;

  // Highest cylinder from the disk size; zero acts as one, anything past the
  // 16-bit range acts as the full range.
  always_comb begin
    if (disk_size_r == '0) begin
      top_calc = '0;
    end else if (disk_size_r[DISK_W-1]) begin
      top_calc = '1;
    end else begin
      top_calc = disk_size_r[POS_W-1:0] - POS_W'(1);
    end
  end

  // Compare unit: a stored request, saturated to the disk, ordered by value
  // and then by store index so that equal cylinders stay distinct.
  assign sat_v     = (rd_data_r > top_r) ? top_r : rd_data_r;
  assign key_c     = {sat_v, rd_idx_r};
  assign bound_key = {head0_r, {IW{1'b1}}};
  assign in_leg    = dir_r ? (key_c > cur_r) : (key_c < cur_r);
  assign better    = !found_r || (dir_r ? (key_c < best_r) : (key_c > best_r));
  assign leg_a_cnt = dir_r ? (count_r - split_r) : split_r;

  // Seek unit: distance from the current head to the next target
  always_comb begin
    if (state_r == ST_SCAN) begin
      target = best_r[KW-1:IW];
    end else begin
      target = dir_r ? top_r : '0;
    end
    sub_a    = dir_r ? target : head_r;
    sub_b    = dir_r ? head_r : target;
    delta    = sub_a - sub_b;
    seek_sum = seek_r + SEEK_W'(delta);
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    addr_nxt        = addr_r;
    found_nxt       = found_r;
    out_valid_nxt   = out_valid_r;
    best_nxt        = best_r;
    cur_nxt         = cur_r;
    split_nxt       = split_r;
    rem_nxt         = rem_r;
    dir_nxt         = dir_r;
    top_nxt         = top_r;
    head0_nxt       = head0_r;
    head_nxt        = head_r;
    seek_nxt        = seek_r;
    out_pos_nxt     = out_pos_r;
    out_edge_nxt    = out_edge_r;
    out_seek_nxt    = out_seek_r;
    out_run_end_nxt = out_run_end_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (mem_we) begin
            count_nxt = count_r + IW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_batch_end) begin
            top_nxt   = top_calc;
            head0_nxt = (start_head_r > top_calc) ? top_calc : start_head_r;
            dir_nxt   = sweep_up_r;
            phase_nxt = PH_CNT;
            addr_nxt  = '0;
            split_nxt = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + IW'(1);
        end
        if (rd_vld_r) begin
          if (phase_r == PH_CNT) begin
            split_nxt = split_r + IW'(sat_v <= head0_r);
          end else if (in_leg && better) begin
            found_nxt = 1'b1;
            best_nxt  = key_c;
          end
        end
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = 1'b0;
          state_nxt     = ST_OUT;
          if (phase_r == PH_CNT) begin
            // Start head leads the schedule
            rem_nxt         = leg_a_cnt;
            out_pos_nxt     = head0_r;
            out_seek_nxt    = '0;
            out_run_end_nxt = 1'b0;
            head_nxt        = head0_r;
            seek_nxt        = '0;
            cur_nxt         = bound_key;
            phase_nxt       = PH_A;
          end else begin
            // Nearest request in the travel direction
            rem_nxt         = rem_r - IW'(1);
            out_pos_nxt     = target;
            out_seek_nxt    = seek_sum;
            out_run_end_nxt = (phase_r == PH_B) && (rem_r == IW'(1));
            head_nxt        = target;
            seek_nxt        = seek_sum;
            cur_nxt         = best_r;
          end
        end
      end

      ST_STEP: begin
        if (rem_r != '0) begin
          addr_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          // Leading side done: run on to the edge and turn around
          out_valid_nxt   = 1'b1;
          out_pos_nxt     = target;
          out_edge_nxt    = 1'b1;
          out_seek_nxt    = seek_sum;
          out_run_end_nxt = (count_r == leg_a_cnt);
          head_nxt        = target;
          seek_nxt        = seek_sum;
          rem_nxt         = count_r - leg_a_cnt;
          dir_nxt         = !dir_r;
          cur_nxt         = bound_key;
          phase_nxt       = PH_B;
          state_nxt       = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_run_end_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      phase_r      <= PH_CNT;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      disk_size_r  <= DISK_SIZE_RST;
      start_head_r <= START_HEAD_RST;
      sweep_up_r   <= SWEEP_UP_RST;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      addr_r      <= addr_nxt;
      rd_vld_r    <= rd_en;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_DISK_SIZE:  disk_size_r  <= cfg_wr_data;
          CFG_START_HEAD: start_head_r <= cfg_wr_data[POS_W-1:0];
          CFG_SWEEP_UP:   sweep_up_r   <= cfg_wr_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx_r      <= addr_r;
    best_r        <= best_nxt;
    cur_r         <= cur_nxt;
    split_r       <= split_nxt;
    rem_r         <= rem_nxt;
    dir_r         <= dir_nxt;
    top_r         <= top_nxt;
    head0_r       <= head0_nxt;
    head_r        <= head_nxt;
    seek_r        <= seek_nxt;
    out_pos_r     <= out_pos_nxt;
    out_edge_r    <= out_edge_nxt;
    out_seek_r    <= out_seek_nxt;
    out_run_end_r <= out_run_end_nxt;
  end

  // Request memory: write on load, registered read during a pass
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= in_cylinder;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr_r[AW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_pos_r;
  assign out_at_edge    = out_edge_r;
  assign out_total_seek = out_seek_r;
  assign out_dropped    = ovf_r;
  assign out_run_end    = out_run_end_r;

  // A new request word is never taken while a result is waiting.
  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid_r)
    else $error("request taken while a result is pending");

  // The fill count never passes the store capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("request count beyond capacity");

  // A pass started for a remaining request must find one.
  a_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_done && phase_r != PH_CNT) |-> found_r)
    else $error("pass over the store found no request");

  // After the turnaround the remaining count covers every result left.
  a_step_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (rem_r != '0 || phase_r == PH_A))
    else $error("step with nothing left after the turnaround");

  // Taking the final result empties the batch and reopens the request side.
  a_run_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_run_end_r) |=> (state_r == ST_LOAD && count_r == '0 && !ovf_r))
    else $error("batch not cleared after the final result");

endmodule

`default_nettype wire
